// File: design/ghre_pkg.sv
// shared types and constants of the gamepad report encoder
`timescale 1ns / 1ps

package ghre_pkg;

   // report layouts selected by the profile register
   typedef enum logic [1:0] {
      PROFILE_GENERIC  = 2'd0,
      PROFILE_CONSOLE  = 2'd1,
      PROFILE_KEYBOARD = 2'd2,
      PROFILE_PSLAYOUT = 2'd3
   } profile_type;

   // hat code for a centered d-pad
   localparam logic [3:0] HAT_NEUTRAL = 4'h8;

   // classified gamepad state handed from the front to the back
   typedef struct packed {
      profile_type profile;
      logic [15:0] buttons;
      logic [3:0]  dir;       // d-pad after opposing directions cancel
      logic [3:0]  hat;       // 0..7 clockwise from up, neutral otherwise
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
   } report_desc_type;

endpackage

// File: design/ghre_front.sv
// front end: profile register, input handshake and d-pad classification
`timescale 1ns / 1ps

module ghre_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [15:0]              req_buttons,
   input  logic [3:0]               req_dpad,
   input  logic signed [7:0]        req_stick_x,
   input  logic signed [7:0]        req_stick_y,
   input  logic                     queue_full,
   output logic                     queue_push,
   output ghre_pkg::report_desc_type queue_desc
);
   import ghre_pkg::*;

   profile_type profile_ff;
   profile_type profile_in;
   logic [1:0]  vert;
   logic [1:0]  horz;
   logic [3:0]  dir;
   logic [3:0]  hat;

   // profile register
   always_comb begin
      profile_in = profile_ff;
      if (csr_write_enable) begin
         profile_in = profile_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= PROFILE_GENERIC;
      end else begin
         profile_ff <= profile_in;
      end
   end

   // opposing directions cancel
   always_comb begin
      vert = (req_dpad[1:0] == 2'b11) ? 2'b00 : req_dpad[1:0];
      horz = (req_dpad[3:2] == 2'b11) ? 2'b00 : req_dpad[3:2];
      dir  = {horz, vert};
   end

   // hat code, diagonals first
   always_comb begin
      if (dir[0] && dir[3]) begin
         hat = 4'd1;
      end else if (dir[1] && dir[3]) begin
         hat = 4'd3;
      end else if (dir[1] && dir[2]) begin
         hat = 4'd5;
      end else if (dir[0] && dir[2]) begin
         hat = 4'd7;
      end else if (dir[0]) begin
         hat = 4'd0;
      end else if (dir[3]) begin
         hat = 4'd2;
      end else if (dir[1]) begin
         hat = 4'd4;
      end else if (dir[2]) begin
         hat = 4'd6;
      end else begin
         hat = HAT_NEUTRAL;
      end
   end

   // handshake and descriptor
   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      queue_desc.profile = profile_ff;
      queue_desc.buttons = req_buttons;
      queue_desc.dir     = dir;
      queue_desc.hat     = hat;
      queue_desc.stick_x = req_stick_x;
      queue_desc.stick_y = req_stick_y;
   end

endmodule

// File: design/ghre_queue.sv
// small descriptor queue between front and back
`timescale 1ns / 1ps

module ghre_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ghre_pkg::report_desc_type push_desc,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output ghre_pkg::report_desc_type head_desc
);
   import ghre_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   report_desc_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: design/ghre_back.sv
// back end: report byte generation and output register
`timescale 1ns / 1ps

module ghre_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  ghre_pkg::report_desc_type head_desc,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_report_byte,
   output logic [4:0]                rsp_byte_index,
   output logic                      rsp_last_byte
);
   import ghre_pkg::*;

   localparam int KEY_COUNT = 15;

   // keyboard usages: B2,L1,R1,L2,R2,S1,S2,L3,R3,A1,A2, then up,down,right,left
   localparam logic [6:0] KEY_USAGE [KEY_COUNT] = '{
      7'h1D, 7'h06, 7'h2C, 7'h19, 7'h1B, 7'h22, 7'h1E, 7'h2E,
      7'h2D, 7'h26, 7'h3B, 7'h52, 7'h51, 7'h4F, 7'h50
   };

   localparam logic [4:0] LAST_GENERIC  = 5'd4;
   localparam logic [4:0] LAST_CONSOLE  = 5'd15;
   localparam logic [4:0] LAST_KEYBOARD = 5'd16;
   localparam logic [4:0] LAST_PSLAYOUT = 5'd6;

   localparam logic [7:0] AXIS_FLIP = 8'h80;
   localparam logic [7:0] AXIS_HIGH = 8'h80;
   localparam logic [7:0] TRIG_LOW  = 8'hFF;
   localparam logic [7:0] TRIG_HIGH = 8'h03;

   logic        valid_ff;
   logic        valid_in;
   logic [7:0]  byte_ff;
   logic [7:0]  byte_in;
   logic [4:0]  index_ff;
   logic [4:0]  index_in;
   logic        last_ff;
   logic        last_in;
   logic [4:0]  count_ff;
   logic [4:0]  count_in;

   logic        load;
   logic [15:0] b;
   logic [15:0] generic_btn;
   logic [15:0] console_btn;
   logic [15:0] ps_btn;
   logic [KEY_COUNT-1:0] keys;
   logic [7:0]  kb_byte;
   logic [3:0]  console_hat;
   logic [4:0]  last_index;
   logic [7:0]  value;

   assign b = head_desc.buttons;

   // button layouts
   always_comb begin
      generic_btn = {b[15], 1'b0, b[13:0]};
      ps_btn      = {2'b00, b[13:0]};
      console_btn = {1'b0, b[11], b[10], b[12], b[9], b[8], 2'b00,
                     b[5], b[4], 1'b0, b[3], b[2], 1'b0, b[1], b[0]};
      console_hat = (head_desc.hat == HAT_NEUTRAL) ? 4'd0 : head_desc.hat + 4'd1;
   end

   // keyboard byte at the current position
   always_comb begin
      keys = {head_desc.dir[2], head_desc.dir[3], head_desc.dir[1], head_desc.dir[0],
              b[13:4], b[1]};
      kb_byte = '0;
      if (count_ff == 5'd0) begin
         kb_byte = {5'b00000, b[3], b[0], b[2]};
      end else begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            if (keys[k] && ({1'b0, KEY_USAGE[k][6:3]} + 5'd1 == count_ff)) begin
               kb_byte = kb_byte | (8'd1 << KEY_USAGE[k][2:0]);
            end
         end
      end
   end

   // byte value and report length per profile
   always_comb begin
      value      = '0;
      last_index = LAST_GENERIC;
      case (head_desc.profile)
         PROFILE_GENERIC: begin
            last_index = LAST_GENERIC;
            case (count_ff)
               5'd0:    value = generic_btn[7:0];
               5'd1:    value = generic_btn[15:8];
               5'd2:    value = {4'h0, head_desc.hat};
               5'd3:    value = head_desc.stick_x;
               5'd4:    value = head_desc.stick_y;
               default: value = '0;
            endcase
         end
         PROFILE_CONSOLE: begin
            last_index = LAST_CONSOLE;
            case (count_ff)
               5'd1:    value = head_desc.stick_x ^ AXIS_FLIP;
               5'd3:    value = head_desc.stick_y ^ AXIS_FLIP;
               5'd5:    value = AXIS_HIGH;
               5'd7:    value = AXIS_HIGH;
               5'd8:    value = b[6] ? TRIG_LOW : 8'h00;
               5'd9:    value = b[6] ? TRIG_HIGH : 8'h00;
               5'd10:   value = b[7] ? TRIG_LOW : 8'h00;
               5'd11:   value = b[7] ? TRIG_HIGH : 8'h00;
               5'd12:   value = {4'h0, console_hat};
               5'd13:   value = console_btn[7:0];
               5'd14:   value = console_btn[15:8];
               default: value = '0;
            endcase
         end
         PROFILE_KEYBOARD: begin
            last_index = LAST_KEYBOARD;
            value      = kb_byte;
         end
         PROFILE_PSLAYOUT: begin
            last_index = LAST_PSLAYOUT;
            case (count_ff)
               5'd0:    value = ps_btn[7:0];
               5'd1:    value = ps_btn[15:8];
               5'd2:    value = {4'h0, head_desc.hat};
               5'd3:    value = head_desc.stick_x;
               5'd4:    value = head_desc.stick_y;
               default: value = '0;
            endcase
         end
         default: begin
            last_index = LAST_GENERIC;
            value      = '0;
         end
      endcase
   end

   // output register loads when the queue has a head and the register is empty or being taken
   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign queue_pop = load && (count_ff == last_index);

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      index_in = index_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = value;
         index_in = count_ff;
         last_in  = (count_ff == last_index);
         count_in = (count_ff == last_index) ? 5'd0 : count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_report_byte = byte_ff;
   assign rsp_byte_index  = index_ff;
   assign rsp_last_byte   = last_ff;

endmodule

// File: design/gamepad_hid_report_encoder_unit.sv
// top level of the gamepad input report encoder
`timescale 1ns / 1ps

// Usage:
//   req_* carries one gamepad state per transaction (buttons, d-pad, stick x/y).
//   rsp_* carries the encoded input report, one byte per transaction, with its
//   position in rsp_byte_index and rsp_last_byte set on the final byte.
//   csr_write_enable/csr_write_data set the report profile (0 generic, 1 console
//   style, 2 keyboard, 3 ps layout); write it only while no report is in flight.
// Path: a request is written into the queue at the accepting edge, and the
//   first byte of its report is then loaded from the queue head into the
//   output register.
// Throughput: one report byte per cycle from the serializer in the back end
//   while rsp_ready is high; a report has 5, 16, 17 or 7 bytes for profiles
//   0 to 3, and requests are taken back to back while the queue has room.
// Reset: the queue and output register empty, the profile returns to generic.
// Stall: when rsp_ready is low the output byte holds; the back end stops, the
//   queue absorbs up to QUEUE_DEPTH states, then req_ready drops.
module gamepad_hid_report_encoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_buttons,
   input  logic [3:0]         req_dpad,
   input  logic signed [7:0]  req_stick_x,
   input  logic signed [7:0]  req_stick_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_report_byte,
   output logic [4:0]         rsp_byte_index,
   output logic               rsp_last_byte
);
   import ghre_pkg::*;

   logic            queue_full;
   logic            queue_push;
   logic            queue_pop;
   logic            head_valid;
   report_desc_type push_desc;
   report_desc_type head_desc;

   // classify and accept
   ghre_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_buttons      (req_buttons),
      .req_dpad         (req_dpad),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_desc       (push_desc)
   );

   // decoupling queue
   ghre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // serialize report bytes
   ghre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_desc       (head_desc),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_report_byte (rsp_report_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule
